// ===== rtl/tsbp_pkg.sv =====
// Shared types and constants for the tone score byte parser.
package tsbp_pkg;

    localparam int DEFAULT_CHANNEL_COUNT = 16;
    localparam int QUEUE_DEPTH           = 2;
    localparam int QUEUE_PTR_W           = 1;
    localparam int QUEUE_CNT_W           = 2;

    localparam int RATE_W = 17;
    localparam int MS_W   = 16;
    localparam int WAIT_W = 23;

    localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;

    localparam logic [7:0] BYTE_END_A = 8'hE0;
    localparam logic [7:0] BYTE_END_B = 8'hF0;

    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;

    // x / 1000 == (x >> 3) / 125; /125 by reciprocal, exact for 30-bit operands
    localparam int          PROD1_W    = MS_W + RATE_W;
    localparam int          DIV_IN_W   = PROD1_W - 3;
    localparam int          DIV_MULT_W = 31;
    localparam int          PROD2_W    = DIV_IN_W + DIV_MULT_W;
    localparam int          DIV_SHIFT  = 37;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = 31'd1099511628;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_KEY,
        PH_VEL,
        PH_INST,
        PH_WAITLO
    } phase_t;

    typedef enum logic [1:0] {
        EV_ON   = 2'd0,
        EV_OFF  = 2'd1,
        EV_WAIT = 2'd2,
        EV_END  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t           kind;
        logic [7:0]      instrument;
        logic [7:0]      note_key;
        logic [7:0]      velocity;
        logic [MS_W-1:0] wait_ms;
    } req_t;

endpackage

// ===== rtl/tsbp_front.sv =====
// Byte parser front end: command decode, channel tables, request generation.
module tsbp_front #(
    parameter int CHANNEL_COUNT = tsbp_pkg::DEFAULT_CHANNEL_COUNT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [7:0]      score_byte,
    output logic            push,
    output tsbp_pkg::req_t  req
);

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    tsbp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       pend_ch_reg, pend_ch_next;
    logic [7:0]       pend_key_reg, pend_key_next;
    logic [7:0]       wait_hi_reg, wait_hi_next;
    logic             fin_reg, fin_next;
    logic [7:0]       inst_tab_reg [CHANNEL_COUNT];
    logic [7:0]       key_tab_reg [CHANNEL_COUNT];
    logic             inst_we;
    logic             key_we;

    logic       pend_ok;
    logic       cmd_ok;
    logic [7:0] pend_inst;
    logic [7:0] cmd_inst;
    logic [7:0] cmd_key;
    logic       is_end;
    logic       active;

    assign pend_ok   = ({1'b0, pend_ch_reg} < 5'(CHANNEL_COUNT));
    assign cmd_ok    = ({1'b0, score_byte[3:0]} < 5'(CHANNEL_COUNT));
    assign pend_inst = pend_ok ? inst_tab_reg[pend_ch_reg[CH_W-1:0]] : 8'd0;
    assign cmd_inst  = cmd_ok ? inst_tab_reg[score_byte[CH_W-1:0]] : 8'd0;
    assign cmd_key   = cmd_ok ? key_tab_reg[score_byte[CH_W-1:0]] : 8'd0;
    assign is_end    = (score_byte == tsbp_pkg::BYTE_END_A) ||
                       (score_byte == tsbp_pkg::BYTE_END_B);
    assign active    = in_fire && !fin_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        pend_ch_next  = pend_ch_reg;
        pend_key_next = pend_key_reg;
        wait_hi_next  = wait_hi_reg;
        fin_next      = fin_reg;
        inst_we       = 1'b0;
        key_we        = 1'b0;
        if (active)
        begin
            case (phase_reg)
                tsbp_pkg::PH_KEY:
                begin
                    pend_key_next = score_byte;
                    phase_next    = tsbp_pkg::PH_VEL;
                end
                tsbp_pkg::PH_VEL:
                begin
                    key_we     = pend_ok;
                    phase_next = tsbp_pkg::PH_CMD;
                end
                tsbp_pkg::PH_INST:
                begin
                    inst_we    = pend_ok;
                    phase_next = tsbp_pkg::PH_CMD;
                end
                tsbp_pkg::PH_WAITLO:
                begin
                    phase_next = tsbp_pkg::PH_CMD;
                end
                tsbp_pkg::PH_CMD:
                begin
                    if (is_end)
                    begin
                        fin_next = 1'b1;
                    end
                    else if (!score_byte[7])
                    begin
                        wait_hi_next = score_byte;
                        phase_next   = tsbp_pkg::PH_WAITLO;
                    end
                    else
                    begin
                        case (score_byte[7:4])
                            tsbp_pkg::NIB_NOTE_ON:
                            begin
                                pend_ch_next = score_byte[3:0];
                                phase_next   = tsbp_pkg::PH_KEY;
                            end
                            tsbp_pkg::NIB_PROGRAM:
                            begin
                                pend_ch_next = score_byte[3:0];
                                phase_next   = tsbp_pkg::PH_INST;
                            end
                            default:
                            begin
                                phase_next = tsbp_pkg::PH_CMD;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = tsbp_pkg::PH_CMD;
                end
            endcase
        end
    end

    always_comb
    begin
        push = 1'b0;
        req  = '0;
        if (active)
        begin
            case (phase_reg)
                tsbp_pkg::PH_VEL:
                begin
                    push           = 1'b1;
                    req.kind       = tsbp_pkg::EV_ON;
                    req.instrument = pend_inst;
                    req.note_key   = pend_key_reg;
                    req.velocity   = score_byte;
                end
                tsbp_pkg::PH_WAITLO:
                begin
                    push        = 1'b1;
                    req.kind    = tsbp_pkg::EV_WAIT;
                    req.wait_ms = {wait_hi_reg, score_byte};
                end
                tsbp_pkg::PH_CMD:
                begin
                    if (is_end)
                    begin
                        push     = 1'b1;
                        req.kind = tsbp_pkg::EV_END;
                    end
                    else if (score_byte[7] && (score_byte[7:4] == tsbp_pkg::NIB_NOTE_OFF))
                    begin
                        push           = 1'b1;
                        req.kind       = tsbp_pkg::EV_OFF;
                        req.instrument = cmd_inst;
                        req.note_key   = cmd_key;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tsbp_pkg::PH_CMD;
            pend_ch_reg  <= 4'd0;
            pend_key_reg <= 8'd0;
            wait_hi_reg  <= 8'd0;
            fin_reg      <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                inst_tab_reg[i] <= 8'd0;
                key_tab_reg[i]  <= 8'd0;
            end
        end
        else
        begin
            phase_reg    <= phase_next;
            pend_ch_reg  <= pend_ch_next;
            pend_key_reg <= pend_key_next;
            wait_hi_reg  <= wait_hi_next;
            fin_reg      <= fin_next;
            if (inst_we)
            begin
                inst_tab_reg[pend_ch_reg[CH_W-1:0]] <= score_byte;
            end
            if (key_we)
            begin
                key_tab_reg[pend_ch_reg[CH_W-1:0]] <= pend_key_reg;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !push)
        else $error("request after end of score");

    a_end_leaves_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> (phase_reg == tsbp_pkg::PH_CMD))
        else $error("finished parser left mid-command");
`endif

endmodule

// ===== rtl/tsbp_queue.sv =====
// Two-entry request queue between parser and scaling pipeline.
module tsbp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsbp_pkg::req_t  push_req,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output tsbp_pkg::req_t  head
);

    tsbp_pkg::req_t                      entry_reg [tsbp_pkg::QUEUE_DEPTH];
    logic [tsbp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [tsbp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [tsbp_pkg::QUEUE_CNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == tsbp_pkg::QUEUE_CNT_W'(tsbp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("request queue underflow");
`endif

endmodule

// ===== rtl/tsbp_back.sv =====
// Back end: ms-to-samples scaling pipeline and output register.
module tsbp_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [tsbp_pkg::RATE_W-1:0]    sample_rate,
    input  logic                           q_valid,
    input  tsbp_pkg::req_t                 q_req,
    output logic                           pop,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [1:0]                     event_kind,
    output logic [7:0]                     instrument,
    output logic [7:0]                     note_key,
    output logic [7:0]                     velocity,
    output logic [tsbp_pkg::WAIT_W-1:0]    wait_samples
);

    logic                              s1_valid_reg;
    tsbp_pkg::req_t                    s1_req_reg;
    logic [tsbp_pkg::PROD1_W-1:0]      s1_prod_reg;
    logic                              s2_valid_reg;
    tsbp_pkg::req_t                    s2_req_reg;
    logic [tsbp_pkg::PROD2_W-1:0]      s2_prod_reg;
    logic                              out_valid_reg;
    tsbp_pkg::req_t                    out_req_reg;
    logic [tsbp_pkg::WAIT_W-1:0]       out_wait_reg;

    logic                              out_ready;
    logic                              s2_ready;
    logic                              s1_ready;
    logic [tsbp_pkg::PROD1_W-1:0]      prod1;
    logic [tsbp_pkg::PROD2_W-1:0]      prod2;
    logic [tsbp_pkg::WAIT_W-1:0]       wait_val;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop       = q_valid && s1_ready;

    assign prod1 = {{tsbp_pkg::RATE_W{1'b0}}, q_req.wait_ms}
                 * {{tsbp_pkg::MS_W{1'b0}}, sample_rate};
    assign prod2 = {{tsbp_pkg::DIV_MULT_W{1'b0}}, s1_prod_reg[tsbp_pkg::PROD1_W-1:3]}
                 * {{tsbp_pkg::DIV_IN_W{1'b0}}, tsbp_pkg::DIV_MULT};

    // tail is half a second; wait results wrap to the field width
    assign wait_val = (s2_req_reg.kind == tsbp_pkg::EV_END)
                    ? tsbp_pkg::WAIT_W'(sample_rate[tsbp_pkg::RATE_W-1:1])
                    : s2_prod_reg[tsbp_pkg::DIV_SHIFT +: tsbp_pkg::WAIT_W];

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_req_reg  <= q_req;
            s1_prod_reg <= prod1;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_req_reg  <= s1_req_reg;
            s2_prod_reg <= prod2;
        end
        if (out_ready && s2_valid_reg)
        begin
            out_req_reg  <= s2_req_reg;
            out_wait_reg <= wait_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= q_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = out_req_reg.kind;
    assign instrument   = out_req_reg.instrument;
    assign note_key     = out_req_reg.note_key;
    assign velocity     = out_req_reg.velocity;
    assign wait_samples = out_wait_reg;

`ifndef SYNTHESIS
    a_note_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((out_req_reg.kind == tsbp_pkg::EV_ON) ||
                          (out_req_reg.kind == tsbp_pkg::EV_OFF))
        |-> (out_wait_reg == '0))
        else $error("note event carries samples");

    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_ready |=> s2_valid_reg && $stable(s2_prod_reg))
        else $error("stage 2 dropped a request under stall");
`endif

endmodule

// ===== rtl/tone_score_byte_parser.sv =====
// Top level of the tone score byte parser.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+--------------------------------------------
//  input    | in_valid  | in_stall  | score_byte
//  output   | out_valid | out_stall | event_kind instrument note_key velocity
//           |           |           | wait_samples
//  config   | cfg_write_en (no stall) | cfg_write_data = sample_rate
//
// One byte per cycle while in_stall is low; each request then passes the request queue
// and the back-end registers in order: ms*rate multiply, reciprocal /1000 multiply, output reg.
// A 2-entry request queue decouples parser and back end; in_stall is queue full.
// Reset clears parse state and channel tables and sets sample_rate to 44100.
module tone_score_byte_parser #(
    parameter int CHANNEL_COUNT = tsbp_pkg::DEFAULT_CHANNEL_COUNT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     score_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     event_kind,
    output logic [7:0]                     instrument,
    output logic [7:0]                     note_key,
    output logic [7:0]                     velocity,
    output logic [tsbp_pkg::WAIT_W-1:0]    wait_samples,
    input  logic                           cfg_write_en,
    input  logic [tsbp_pkg::RATE_W-1:0]    cfg_write_data
);

    logic [tsbp_pkg::RATE_W-1:0] rate_reg;
    logic                        in_fire;
    logic                        push;
    tsbp_pkg::req_t              push_req;
    logic                        pop;
    logic                        q_full;
    logic                        q_valid;
    tsbp_pkg::req_t              q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= tsbp_pkg::RATE_RESET;
        end
        else if (cfg_write_en)
        begin
            rate_reg <= cfg_write_data;
        end
    end

    assign in_stall = q_full;
    assign in_fire  = in_valid && !q_full;

    tsbp_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .score_byte (score_byte),
        .push       (push),
        .req        (push_req)
    );

    tsbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    tsbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_rate  (rate_reg),
        .q_valid      (q_valid),
        .q_req        (q_head),
        .pop          (pop),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .event_kind   (event_kind),
        .instrument   (instrument),
        .note_key     (note_key),
        .velocity     (velocity),
        .wait_samples (wait_samples)
    );

endmodule
